/* src/packet_frame_checker_core_macros.svh */
// assertion macros used by the frame checker assertions in pfc_checker
`ifndef PACKET_FRAME_CHECKER_CORE_MACROS_SVH
`define PACKET_FRAME_CHECKER_CORE_MACROS_SVH

// same-cycle implication, quiet during reset
`define PFC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet during reset
`define PFC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/pfc_pkg.sv */
// ----------------------------------------------------------------------------
// pfc_pkg
// Types, constants and the CRC byte update shared by the frame checker files.
// ----------------------------------------------------------------------------
package pfc_pkg;

  localparam int HDR_BYTES       = 18;
  localparam int CRC_FIELD_POS   = 14;
  localparam int CRC_COVER_BYTES = 14;
  localparam int HIDX_W          = 5;

  localparam longint MAX_PAYLOAD = 65535;
  // payload countdown never holds more than the largest accepted length
  localparam int REM_W = $clog2(MAX_PAYLOAD + 1);

  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HEADER,
    PH_PAYLOAD,
    PH_DISCARD
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_MAGIC   = 3'd1,
    ST_BAD_VERSION = 3'd2,
    ST_BAD_CRC     = 3'd3,
    ST_TOO_LONG    = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    REG_CRC_POLY    = 3'd0,
    REG_CRC_INIT    = 3'd1,
    REG_CRC_XOR     = 3'd2,
    REG_MAGIC       = 3'd3,
    REG_VERSION     = 3'd4,
    REG_CRC_ENABLE  = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [31:0] crc_polynomial;
    logic [31:0] crc_initial;
    logic [31:0] crc_final_xor;
    logic [15:0] expected_magic;
    logic [7:0]  expected_version;
    logic        crc_check_enable;
  } cfg_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  frame_type;
    logic [15:0] pkt_flags;
    logic [31:0] sequence_res;
    logic [31:0] frame_length;
    logic [31:0] received_crc;
    logic [31:0] computed_crc;
  } result_t;

  // reflected crc-32, one byte through eight shift-xor steps
  function automatic logic [31:0] crc_byte(input logic [31:0] acc, input logic [7:0] b,
                                           input logic [31:0] poly);
    logic [31:0] a;
    a = acc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      a = a[0] ? ((a >> 1) ^ poly) : (a >> 1);
    end
    return a;
  endfunction

endpackage

/* src/pfc_regs.sv */
// ----------------------------------------------------------------------------
// pfc_regs
// APB configuration registers of the frame checker.
// ----------------------------------------------------------------------------
module pfc_regs
  import pfc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  reg_idx_t idx;
  logic     wr;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.crc_polynomial   <= 32'hEDB8_8320;
      cfg.crc_initial      <= 32'hFFFF_FFFF;
      cfg.crc_final_xor    <= 32'hFFFF_FFFF;
      cfg.expected_magic   <= 16'd0;
      cfg.expected_version <= 8'd1;
      cfg.crc_check_enable <= 1'b1;
    end else if (wr) begin
      case (idx)
        REG_CRC_POLY:   cfg.crc_polynomial   <= pwdata;
        REG_CRC_INIT:   cfg.crc_initial      <= pwdata;
        REG_CRC_XOR:    cfg.crc_final_xor    <= pwdata;
        REG_MAGIC:      cfg.expected_magic   <= pwdata[15:0];
        REG_VERSION:    cfg.expected_version <= pwdata[7:0];
        REG_CRC_ENABLE: cfg.crc_check_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_CRC_POLY:   prdata = cfg.crc_polynomial;
      REG_CRC_INIT:   prdata = cfg.crc_initial;
      REG_CRC_XOR:    prdata = cfg.crc_final_xor;
      REG_MAGIC:      prdata = {16'd0, cfg.expected_magic};
      REG_VERSION:    prdata = {24'd0, cfg.expected_version};
      REG_CRC_ENABLE: prdata = {31'd0, cfg.crc_check_enable};
      default:        prdata = '0;
    endcase
  end

endmodule

/* src/pfc_parser.sv */
// ----------------------------------------------------------------------------
// pfc_parser
// Header parse state, crc accumulator and verdict for one byte per cycle while fire is high.
// ----------------------------------------------------------------------------
module pfc_parser
  import pfc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  logic [7:0] rx_byte,
  input  logic       start_of_packet,
  input  cfg_t       cfg,
  output logic       res_valid,
  output result_t    res
);

  phase_t            phase, phase_next;
  logic [HIDX_W-1:0] hidx, hidx_next;
  logic [7:0]        magic_low, magic_low_next;
  logic [7:0]        type_reg, type_next;
  logic [15:0]       flags_reg, flags_next;
  logic [31:0]       sequence_reg, sequence_next;
  logic [31:0]       length_reg, length_next;
  logic [31:0]       hcrc_reg, hcrc_next;
  logic [REM_W-1:0]  remaining, remaining_next;
  logic [31:0]       acc, acc_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      hidx         <= '0;
      magic_low    <= '0;
      type_reg     <= '0;
      flags_reg    <= '0;
      sequence_reg <= '0;
      length_reg   <= '0;
      hcrc_reg     <= '0;
      remaining    <= '0;
      acc          <= '0;
    end else if (fire) begin
      phase        <= phase_next;
      hidx         <= hidx_next;
      magic_low    <= magic_low_next;
      type_reg     <= type_next;
      flags_reg    <= flags_next;
      sequence_reg <= sequence_next;
      length_reg   <= length_next;
      hcrc_reg     <= hcrc_next;
      remaining    <= remaining_next;
      acc          <= acc_next;
    end
  end

  always_comb begin
    logic        verdict;
    logic [31:0] fin;
    logic [1:0]  off;
    phase_t      ph;

    phase_next     = phase;
    hidx_next      = hidx;
    magic_low_next = magic_low;
    type_next      = type_reg;
    flags_next     = flags_reg;
    sequence_next  = sequence_reg;
    length_next    = length_reg;
    hcrc_next      = hcrc_reg;
    remaining_next = remaining;
    acc_next       = acc;
    res_valid      = 1'b0;
    res            = '0;
    verdict        = 1'b0;
    off            = '0;
    ph             = phase;

    // start flag restarts parsing with this byte as header byte 0
    if (start_of_packet) begin
      ph             = PH_HEADER;
      hidx_next      = '0;
      type_next      = '0;
      flags_next     = '0;
      sequence_next  = '0;
      length_next    = '0;
      hcrc_next      = '0;
      remaining_next = '0;
      acc_next       = cfg.crc_initial;
    end
    phase_next = ph;

    case (ph)
      PH_PAYLOAD: begin
        acc_next       = crc_byte(acc_next, rx_byte, cfg.crc_polynomial);
        remaining_next = remaining_next - REM_W'(1);
        if (remaining_next == '0) begin
          verdict = 1'b1;
        end
      end
      PH_HEADER: begin
        if (hidx_next < HIDX_W'(CRC_COVER_BYTES)) begin
          acc_next = crc_byte(acc_next,
                              (hidx_next >= HIDX_W'(CRC_FIELD_POS)) ? 8'd0 : rx_byte,
                              cfg.crc_polynomial);
        end
        if (hidx_next == HIDX_W'(0)) begin
          magic_low_next = rx_byte;
        end else if (hidx_next == HIDX_W'(1)) begin
          if ({rx_byte, magic_low} != cfg.expected_magic) begin
            phase_next = PH_DISCARD;
            res_valid  = 1'b1;
            res.status = ST_BAD_MAGIC;
          end
        end else if (hidx_next == HIDX_W'(2)) begin
          if (rx_byte != cfg.expected_version) begin
            phase_next = PH_DISCARD;
            res_valid  = 1'b1;
            res.status = ST_BAD_VERSION;
          end
        end else if (hidx_next == HIDX_W'(3)) begin
          type_next = rx_byte;
        end else if (hidx_next < HIDX_W'(6)) begin
          off = 2'(hidx_next - HIDX_W'(4));
          flags_next[{off[0], 3'b000} +: 8] = rx_byte;
        end else if (hidx_next < HIDX_W'(10)) begin
          off = 2'(hidx_next - HIDX_W'(6));
          sequence_next[{off, 3'b000} +: 8] = rx_byte;
        end else if (hidx_next < HIDX_W'(14)) begin
          off = 2'(hidx_next - HIDX_W'(10));
          length_next[{off, 3'b000} +: 8] = rx_byte;
        end else begin
          off = 2'(hidx_next - HIDX_W'(14));
          hcrc_next[{off, 3'b000} +: 8] = rx_byte;
        end

        if (!res_valid) begin
          if (hidx_next == HIDX_W'(HDR_BYTES - 1)) begin
            hidx_next = '0;
            if (64'(length_next) > 64'(MAX_PAYLOAD)) begin
              phase_next         = PH_DISCARD;
              res_valid          = 1'b1;
              res.status         = ST_TOO_LONG;
              res.frame_type     = type_next;
              res.pkt_flags      = flags_next;
              res.sequence_res   = sequence_next;
              res.frame_length   = length_next;
              res.received_crc   = hcrc_next;
            end else if (length_next == 32'd0) begin
              verdict = 1'b1;
            end else begin
              remaining_next = REM_W'(length_next);
              phase_next     = PH_PAYLOAD;
            end
          end else begin
            hidx_next = hidx_next + HIDX_W'(1);
          end
        end
      end
      default: ;
    endcase

    fin = acc_next ^ cfg.crc_final_xor;
    if (verdict) begin
      phase_next         = PH_IDLE;
      res_valid          = 1'b1;
      res.status         = (!cfg.crc_check_enable || fin == hcrc_next) ? ST_OK : ST_BAD_CRC;
      res.frame_type     = type_next;
      res.pkt_flags      = flags_next;
      res.sequence_res   = sequence_next;
      res.frame_length   = length_next;
      res.received_crc   = hcrc_next;
      res.computed_crc   = fin;
    end
  end

endmodule

/* src/packet_frame_checker_core.sv */
// ----------------------------------------------------------------------------
// packet_frame_checker_core
// Receive-side frame checker: header parse, magic, version and length check, crc-32.
// ----------------------------------------------------------------------------
// datapath: an accepted input word goes into the input register; parse and crc then
// write its result into the result register when the stage word moves on
// throughput: one word per cycle, the byte-wide crc update sets the path;
// while a result word waits with out_ready low the input stage stalls
// reset: synchronous rst clears handshake state, parse state and config registers
// to their defaults, no clearing pass; the data registers are not reset
module packet_frame_checker_core
  import pfc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         rx_byte,
  input  logic               start_of_packet,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         status,
  output logic [7:0]         frame_type,
  output logic [15:0]        pkt_flags,
  output logic [31:0]        sequence_res,
  output logic [31:0]        frame_length,
  output logic [31:0]        received_crc,
  output logic [31:0]        computed_crc
);

  cfg_t       cfg;
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_sop;
  logic       s1_fire;
  logic       res_valid;
  result_t    res;
  result_t    out_res;

  pfc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // stage word moves on whenever the result register is free or being taken
  assign s1_fire  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= rx_byte;
      s1_sop  <= start_of_packet;
    end
  end

  pfc_parser u_parser (
    .clk             (clk),
    .rst             (rst),
    .fire            (s1_fire),
    .rx_byte         (s1_byte),
    .start_of_packet (s1_sop),
    .cfg             (cfg),
    .res_valid       (res_valid),
    .res             (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && res_valid) begin
      out_res <= res;
    end
  end

  assign status         = out_res.status;
  assign frame_type     = out_res.frame_type;
  assign pkt_flags      = out_res.pkt_flags;
  assign sequence_res   = out_res.sequence_res;
  assign frame_length   = out_res.frame_length;
  assign received_crc   = out_res.received_crc;
  assign computed_crc   = out_res.computed_crc;

endmodule

/* src/pfc_checker.sv */
// ----------------------------------------------------------------------------
// pfc_checker
// Port-level checks on the frame checker results, bound to the top level.
// ----------------------------------------------------------------------------
`include "packet_frame_checker_core_macros.svh"

module pfc_checker
  import pfc_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic [7:0]  frame_type,
  input logic [31:0] frame_length,
  input logic [31:0] received_crc,
  input logic [31:0] computed_crc
);

  logic        early_fail;
  logic        early_out;
  logic        early_fields_zero;
  logic        stalled;
  logic [34:0] held_word;
  logic        len_over;
  logic        too_long_out;
  logic        too_long_ok;
  logic        crc_out;

  assign early_fail = (status == ST_BAD_MAGIC) || (status == ST_BAD_VERSION);
  assign early_out  = out_valid && early_fail;
  assign early_fields_zero = (frame_type == 8'd0) && (frame_length == 32'd0) &&
                             (received_crc == 32'd0) && (computed_crc == 32'd0);
  assign stalled      = out_valid && !out_ready;
  assign held_word    = {status, computed_crc};
  assign len_over     = 64'(frame_length) > 64'(MAX_PAYLOAD);
  assign too_long_out = out_valid && (status == ST_TOO_LONG);
  assign too_long_ok  = (computed_crc == 32'd0) && len_over;
  assign crc_out      = out_valid && ((status == ST_OK) || (status == ST_BAD_CRC));

  `PFC_ASSERT_NXT(a_out_hold, stalled, out_valid && $stable(held_word), "held word changed")
  `PFC_ASSERT_IMP(a_early_zero, early_out, early_fields_zero, "fields on early failure")
  `PFC_ASSERT_IMP(a_too_long, too_long_out, too_long_ok, "bad too-long verdict")
  `PFC_ASSERT_IMP(a_ok_len, crc_out, !len_over, "crc verdict on an oversize payload")

endmodule

bind packet_frame_checker_core pfc_checker u_pfc_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .status         (status),
  .frame_type     (frame_type),
  .frame_length   (frame_length),
  .received_crc   (received_crc),
  .computed_crc   (computed_crc)
);
